@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Both macros sample on the rising clock edge and stand down during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in the same cycle.
`define ASSERT_NOW(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/icc_reasm_pkg.sv @@
package icc_reasm_pkg;

  localparam int unsigned DEF_MAX_SEGMENTS = 255;
  localparam int unsigned HEADER_BYTES     = 14;

  localparam logic [7:0]  APP2_CODE = 8'hE2;
  localparam logic [63:0] TAG_HIGH  = 64'h4943435F50524F46;
  localparam logic [31:0] TAG_LOW   = 32'h494C4500;

  typedef enum logic [1:0] {
    ACT_SCAN   = 2'd0,
    ACT_FINISH = 2'd1,
    ACT_PLACE  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_COUNT   = 3'd1,
    ST_SEQ     = 3'd2,
    ST_DUP     = 3'd3,
    ST_NONE    = 3'd4,
    ST_MISSING = 3'd5,
    ST_EMPTY   = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  marker_code;
    logic [15:0] segment_length;
    logic [63:0] tag_bytes_high;
    logic [31:0] tag_bytes_low;
    logic [7:0]  seq_byte;
    logic [7:0]  count_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_icc;
    logic [2:0]  status;
    logic        found;
    logic [23:0] profile_bytes;
    logic [23:0] dest_offset;
    logic [15:0] payload_length;
  } out_item_t;

endpackage

@@ hdl/icc_reasm_ram.sv @@
module icc_reasm_ram import icc_reasm_pkg::*; #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = DEF_MAX_SEGMENTS + 1,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/icc_app2_segment_reassembly.sv @@
// ICC profile reassembly bookkeeping for JPEG APP2 markers. Each input transfer
// carries one action. A scan transfer presents one saved marker: the block
// decides whether it is an ICC chunk (APP2 code, at least 14 data bytes and the
// ICC profile tag), records its sequence number and payload length, and
// reports the sticky error state, which latches on the first inconsistent
// count, bad sequence number or duplicate chunk. A finish transfer walks the
// chunks from one to the expected count, stops at the first missing one,
// assigns each chunk its payload offset by a running sum and reports the
// total profile length; it then clears the profile state, but the offsets are
// kept so that place transfers can follow. A place transfer returns an ICC
// marker's destination offset and payload length; any other marker gets an
// all-zero result. Every input transfer gives exactly one result transfer.
// Scan transfers, non-ICC place transfers and transfers with an unused action
// code can be accepted back to back while the consumer keeps up; an ICC place
// transfer passes through the place state, because the offset memory has a
// registered read port; a finish transfer is answered without a walk when an
// error is pending or no chunk was seen, and otherwise at the end of the walk
// over the chunks, which is paced by the single 24-bit accumulator and the one
// read port of the length memory. The block accepts no input while a finish or
// place transfer is in progress, nor while a result is held that the consumer
// is not taking. The chunk-present flags are flip-flops cleared directly by
// reset and by every finish, so no clearing pass is needed after reset. Offsets
// of chunks never assigned by a finish transfer read back as arbitrary values.
module icc_app2_segment_reassembly import icc_reasm_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned DEPTH = MAX_SEGMENTS + 1;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0]  MAX_SEG_B = 8'(MAX_SEGMENTS);
  localparam logic [15:0] HDR_B     = 16'(HEADER_BYTES);

  // One-hot sequencer: idle, walking the chunk list, or waiting on the
  // offset memory for a place transfer.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_PLACE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       expected_q, expected_d;
  status_e          error_q, error_d;
  logic [DEPTH-1:0] present_q, present_d;
  logic [23:0]      total_q, total_d;
  logic [7:0]       step_q, step_d;
  logic [15:0]      place_len_q, place_len_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             in_fire;
  logic             is_icc;
  logic [7:0]       exp_eff;
  logic [15:0]      pay_len;
  logic [IDX_W-1:0] seq_idx;
  logic [IDX_W-1:0] step_idx;
  logic [7:0]       step_next;
  logic             step_in_range;
  logic [23:0]      sum;
  logic             clear_profile;

  logic             len_we;
  logic [IDX_W-1:0] len_raddr;
  logic [15:0]      len_rdata;
  logic             off_we;
  logic [23:0]      off_rdata;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // ICC recognition on the code, the length and the twelve tag bytes.
  assign is_icc = (in_data_i.marker_code == APP2_CODE) &&
                  (in_data_i.segment_length >= HDR_B) &&
                  (in_data_i.tag_bytes_high == TAG_HIGH) &&
                  (in_data_i.tag_bytes_low == TAG_LOW);

  // The first ICC chunk of a profile fixes the expected count.
  assign exp_eff  = (expected_q == 8'd0) ? in_data_i.count_byte : expected_q;
  assign pay_len  = in_data_i.segment_length - HDR_B;
  assign seq_idx  = in_data_i.seq_byte[IDX_W-1:0];

  // The walk uses the single accumulator; the length memory is read one step
  // ahead so that each step finds its chunk length already registered.
  assign step_idx      = step_q[IDX_W-1:0];
  assign step_next     = step_q + 8'd1;
  assign step_in_range = (step_q <= MAX_SEG_B);
  assign sum           = total_q + {8'd0, len_rdata};
  assign len_raddr     = (state_q == S_WALK) ? step_next[IDX_W-1:0] : IDX_W'(1);

  always_comb begin
    state_d       = state_q;
    expected_d    = expected_q;
    error_d       = error_q;
    present_d     = present_q;
    total_d       = total_q;
    step_d        = step_q;
    place_len_d   = place_len_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    len_we        = 1'b0;
    off_we        = 1'b0;
    clear_profile = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          case (in_data_i.action)
            ACT_SCAN: begin
              // Once an error is latched, scan transfers leave the state alone.
              if (is_icc && (error_q == ST_OK)) begin
                if ((expected_q != 8'd0) && (expected_q != in_data_i.count_byte)) begin
                  error_d = ST_COUNT;
                end else begin
                  expected_d = exp_eff;
                  if ((in_data_i.seq_byte == 8'd0) || (in_data_i.seq_byte > exp_eff) ||
                      (in_data_i.seq_byte > MAX_SEG_B)) begin
                    error_d = ST_SEQ;
                  end else if (present_q[seq_idx]) begin
                    error_d = ST_DUP;
                  end else begin
                    present_d[seq_idx] = 1'b1;
                    len_we             = 1'b1;
                  end
                end
              end
              out_d.is_icc = is_icc;
              out_d.status = error_d;
            end
            ACT_FINISH: begin
              if (error_q != ST_OK) begin
                out_d.status  = error_q;
                clear_profile = 1'b1;
              end else if (expected_q == 8'd0) begin
                out_d.status  = ST_NONE;
                clear_profile = 1'b1;
              end else begin
                // The result is produced at the end of the walk.
                out_valid_d = 1'b0;
                total_d     = '0;
                step_d      = 8'd1;
                state_d     = S_WALK;
              end
            end
            ACT_PLACE: begin
              if (is_icc) begin
                // Wait in the place state for the registered offset read.
                out_valid_d = 1'b0;
                place_len_d = pay_len;
                state_d     = S_PLACE;
              end
            end
            default: begin
              // An unused action code gives an all-zero result.
            end
          endcase
        end
      end
      S_WALK: begin
        if (!step_in_range || !present_q[step_idx]) begin
          out_valid_d   = 1'b1;
          out_d         = '0;
          out_d.status  = ST_MISSING;
          clear_profile = 1'b1;
          state_d       = S_IDLE;
        end else begin
          off_we  = 1'b1;
          total_d = sum;
          step_d  = step_next;
          if (step_q == expected_q) begin
            out_valid_d = 1'b1;
            out_d       = '0;
            if (sum == 24'd0) begin
              out_d.status = ST_EMPTY;
            end else begin
              out_d.status        = ST_OK;
              out_d.found         = 1'b1;
              out_d.profile_bytes = sum;
            end
            clear_profile = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      S_PLACE: begin
        out_valid_d          = 1'b1;
        out_d                = '0;
        out_d.is_icc         = 1'b1;
        out_d.dest_offset    = off_rdata;
        out_d.payload_length = place_len_q;
        state_d              = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Every finish leaves the profile state empty for the next one.
    if (clear_profile) begin
      present_d  = '0;
      expected_d = 8'd0;
      error_d    = ST_OK;
      total_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      expected_q  <= 8'd0;
      error_q     <= ST_OK;
      present_q   <= '0;
      total_q     <= '0;
      step_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      expected_q  <= expected_d;
      error_q     <= error_d;
      present_q   <= present_d;
      total_q     <= total_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    place_len_q <= place_len_d;
    out_q       <= out_d;
  end

  // Payload length of each recorded chunk, indexed by sequence number.
  icc_reasm_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (seq_idx),
    .wdata_i (pay_len),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // Payload offset of each chunk, written during the finish walk.
  icc_reasm_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (step_idx),
    .wdata_i (total_q),
    .raddr_i (seq_idx),
    .rdata_o (off_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/icc_reasm_chk.sv @@
`include "assert_macros.svh"

module icc_reasm_chk import icc_reasm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `ASSERT_NOW(a_ready_room, clk_i, rst_ni, in_ready_o |-> (!out_valid_o || out_ready_i), "input taken with no room for its result")
  `ASSERT_NEXT(a_scan_result, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.action == ACT_SCAN, out_valid_o, "scan result not presented on the next cycle")
  `ASSERT_NOW(a_found_ok, clk_i, rst_ni, out_valid_o && out_data_o.found |-> out_data_o.status == ST_OK && out_data_o.profile_bytes != 24'd0, "found reported with a bad status or an empty profile")
  `ASSERT_NOW(a_non_icc_place, clk_i, rst_ni, out_valid_o && !out_data_o.is_icc |-> out_data_o.dest_offset == 24'd0 && out_data_o.payload_length == 16'd0, "placement fields set for a non-ICC result")

endmodule

bind icc_app2_segment_reassembly icc_reasm_chk u_icc_reasm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
